// File: src/nbga_pkg.sv
// Package with the shared types, codes and constants of the gravity kernel.
`timescale 1ns / 1ps

package nbga_pkg;

    // Body store size and index widths.
    localparam int          IDX_W      = 10;
    localparam int          CNT_W      = 11;
    localparam logic [10:0] MAX_BODIES = 11'd1024;

    // Last iteration indices of the shared serial units.
    localparam logic [6:0] DIV_LAST  = 7'd69;
    localparam logic [6:0] SQRT_LAST = 7'd31;
    localparam logic [6:0] MUL_LAST  = 7'd3;

    // Operation codes.
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_SKIP  = 2'd2;
    localparam logic [1:0] ST_SAT   = 2'd3;

    // Input word.
    typedef struct packed {
        logic        opcode;
        logic [9:0]  body_index;
        logic [31:0] body_mass;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
    } req_t;

    // Result word.
    typedef struct packed {
        logic [47:0] acc_x;
        logic [47:0] acc_y;
        logic [47:0] acc_z;
        logic [1:0]  status;
    } rsp_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_TRD,
        S_TCAP,
        S_JRD,
        S_JCAP,
        S_SQ,
        S_RCHK,
        S_SQRT,
        S_GDIV,
        S_UDIV,
        S_MUL,
        S_ACC,
        S_NEXT,
        S_SAT,
        S_DONE
    } state_t;

endpackage

// File: src/nbody_gravity_acceleration_top.sv
// Direct-sum gravity kernel: body store, serial sequencer and result register.
`timescale 1ns / 1ps

// A load word writes one body into the 1024-entry store; its acknowledge passes
// through the done state and is registered once the output register is free.
// A query word sums the pull of every other body below body_count on the target,
// one body at a time through one shared 33x33 multiplier, one bit-serial square
// root (32 steps) and one bit-serial restoring divider (70 steps, used once for
// the mass term and once per axis). A coincident body is skipped after the
// distance check, and a query with an out-of-range target goes straight to the
// done state. The block takes no new word while a query runs, but it does take
// one while a finished result waits in the output register.
module nbody_gravity_acceleration_top (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_stall,
    input  nbga_pkg::req_t         req,
    output logic                   rsp_valid,
    input  logic                   rsp_stall,
    output nbga_pkg::rsp_t         rsp,
    input  logic                   cfg_we,
    input  logic [10:0]            cfg_wdata
);

    // Body store: mass, x, y, z.
    logic [127:0] body_mem [1024];
    logic [127:0] rd_data_reg;
    logic         mem_we;
    logic         rd_en;
    logic [9:0]   rd_addr;

    nbga_pkg::state_t state_reg, state_next;

    logic [10:0]       body_count_reg;
    logic [9:0]        idx_reg, idx_next;
    logic [10:0]       j_reg, j_next;
    logic [1:0]        ax_reg, ax_next;
    logic [6:0]        cnt_reg, cnt_next;
    logic [2:0][31:0]  tgt_reg, tgt_next;
    logic [31:0]       mass_reg, mass_next;
    logic [2:0][32:0]  d_reg, d_next;
    logic [63:0]       r2_reg, r2_next;
    logic [63:0]       sq_v_reg, sq_v_next;
    logic [63:0]       sq_res_reg, sq_res_next;
    logic [63:0]       sq_bit_reg, sq_bit_next;
    logic [69:0]       num_reg, num_next;
    logic [64:0]       rem_reg, rem_next;
    logic [69:0]       quo_reg, quo_next;
    logic [63:0]       den_reg, den_next;
    logic [62:0]       g_reg, g_next;
    logic [61:0]       u_reg, u_next;
    logic [127:0]      prod_reg, prod_next;
    logic [2:0][63:0]  acc_reg, acc_next;
    logic              skip_reg, skip_next;
    logic              clip_reg, clip_next;
    nbga_pkg::rsp_t    res_reg, res_next;
    nbga_pkg::rsp_t    rsp_reg;
    logic              rsp_valid_reg;

    logic              req_acc;
    logic              rsp_free;
    logic [10:0]       n_use;

    // Shared arithmetic.
    logic [32:0]  mul_a, mul_b;
    logic [65:0]  mul_p;
    logic [127:0] pp_shift;
    logic [63:0]  sq_sum;
    logic         sq_ge;
    logic [64:0]  rem_sh;
    logic         div_ge;
    logic [64:0]  rem_step;
    logic [69:0]  quo_step;
    logic [32:0]  mag_cur, mag_nxt;
    logic [50:0]  term;
    logic         term_clip;
    logic [63:0]  acc_sum;
    logic [2:0][47:0] sat_val;
    logic [2:0]       sat_hit;

    assign req_acc  = req_valid && !req_stall;
    assign rsp_free = !rsp_valid_reg || !rsp_stall;
    assign n_use    = (body_count_reg > nbga_pkg::MAX_BODIES) ? nbga_pkg::MAX_BODIES
                                                              : body_count_reg;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Magnitudes of the current and next axis offsets.
    assign mag_cur = d_reg[ax_reg][32] ? (33'd0 - d_reg[ax_reg]) : d_reg[ax_reg];
    assign mag_nxt = d_reg[ax_reg + 2'd1][32] ? (33'd0 - d_reg[ax_reg + 2'd1])
                                              : d_reg[ax_reg + 2'd1];

    // Multiplier operand selection: squares, then the four partial products.
    always_comb
    begin
        if (state_reg == nbga_pkg::S_MUL)
        begin
            mul_a = cnt_reg[0] ? {3'b0, u_reg[61:32]} : {1'b0, u_reg[31:0]};
            mul_b = cnt_reg[1] ? {2'b0, g_reg[62:32]} : {1'b0, g_reg[31:0]};
        end
        else
        begin
            mul_a = mag_cur;
            mul_b = mag_cur;
        end
    end

    assign mul_p = mul_a * mul_b;

    always_comb
    begin
        case (cnt_reg[1:0])
            2'd0:    pp_shift = {62'b0, mul_p};
            2'd3:    pp_shift = {mul_p[63:0], 64'b0};
            default: pp_shift = {30'b0, mul_p, 32'b0};
        endcase
    end

    // One square-root step and one restoring-division step.
    assign sq_sum   = sq_res_reg + sq_bit_reg;
    assign sq_ge    = sq_v_reg >= sq_sum;
    assign rem_sh   = {rem_reg[63:0], num_reg[69]};
    assign div_ge   = rem_sh >= {1'b0, den_reg};
    assign rem_step = div_ge ? (rem_sh - {1'b0, den_reg}) : rem_sh;
    assign quo_step = {quo_reg[68:0], div_ge};

    // Term clip and signed accumulate.
    assign term_clip = prod_reg[127:80] != 48'd0;
    assign term      = term_clip ? {1'b1, 50'b0} : {1'b0, prod_reg[79:30]};
    assign acc_sum   = d_reg[ax_reg][32] ? (acc_reg[ax_reg] - {13'b0, term})
                                         : (acc_reg[ax_reg] + {13'b0, term});

    // Saturation of the three sums to 48 bits.
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            if ($signed(acc_reg[a]) > $signed(64'sh0000_7FFF_FFFF_FFFF))
            begin
                sat_val[a] = 48'h7FFF_FFFF_FFFF;
                sat_hit[a] = 1'b1;
            end
            else if ($signed(acc_reg[a]) < $signed(-64'sh0000_8000_0000_0000))
            begin
                sat_val[a] = 48'h8000_0000_0000;
                sat_hit[a] = 1'b1;
            end
            else
            begin
                sat_val[a] = acc_reg[a][47:0];
                sat_hit[a] = 1'b0;
            end
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            nbga_pkg::S_IDLE:
                if (req_acc)
                begin
                    if (req.opcode == nbga_pkg::OP_QUERY && {1'b0, req.body_index} < n_use)
                        state_next = nbga_pkg::S_TRD;
                    else
                        state_next = nbga_pkg::S_DONE;
                end
            nbga_pkg::S_TRD:  state_next = nbga_pkg::S_TCAP;
            nbga_pkg::S_TCAP: state_next = nbga_pkg::S_JRD;
            nbga_pkg::S_JRD:
                state_next = (j_reg == {1'b0, idx_reg}) ? nbga_pkg::S_NEXT : nbga_pkg::S_JCAP;
            nbga_pkg::S_JCAP: state_next = nbga_pkg::S_SQ;
            nbga_pkg::S_SQ:
                if (ax_reg == 2'd2)
                    state_next = nbga_pkg::S_RCHK;
            nbga_pkg::S_RCHK:
                state_next = (r2_reg == 64'd0) ? nbga_pkg::S_NEXT : nbga_pkg::S_SQRT;
            nbga_pkg::S_SQRT:
                if (cnt_reg == nbga_pkg::SQRT_LAST)
                    state_next = nbga_pkg::S_GDIV;
            nbga_pkg::S_GDIV:
                if (cnt_reg == nbga_pkg::DIV_LAST)
                    state_next = nbga_pkg::S_UDIV;
            nbga_pkg::S_UDIV:
                if (cnt_reg == nbga_pkg::DIV_LAST)
                    state_next = nbga_pkg::S_MUL;
            nbga_pkg::S_MUL:
                if (cnt_reg == nbga_pkg::MUL_LAST)
                    state_next = nbga_pkg::S_ACC;
            nbga_pkg::S_ACC:
                state_next = (ax_reg == 2'd2) ? nbga_pkg::S_NEXT : nbga_pkg::S_UDIV;
            nbga_pkg::S_NEXT:
                state_next = (j_reg + 11'd1 == n_use) ? nbga_pkg::S_SAT : nbga_pkg::S_JRD;
            nbga_pkg::S_SAT:  state_next = nbga_pkg::S_DONE;
            nbga_pkg::S_DONE:
                if (rsp_free)
                    state_next = nbga_pkg::S_IDLE;
            default: state_next = nbga_pkg::S_IDLE;
        endcase
    end

    // Control outputs.
    always_comb
    begin
        req_stall = state_reg != nbga_pkg::S_IDLE;
        mem_we    = req_acc && req.opcode == nbga_pkg::OP_LOAD &&
                    {1'b0, req.body_index} < nbga_pkg::MAX_BODIES;
        rd_en     = state_reg == nbga_pkg::S_TRD ||
                    (state_reg == nbga_pkg::S_JRD && j_reg != {1'b0, idx_reg});
        rd_addr   = (state_reg == nbga_pkg::S_TRD) ? idx_reg : j_reg[9:0];
    end

    // Datapath next values.
    always_comb
    begin
        idx_next    = idx_reg;
        j_next      = j_reg;
        ax_next     = ax_reg;
        cnt_next    = cnt_reg;
        tgt_next    = tgt_reg;
        mass_next   = mass_reg;
        d_next      = d_reg;
        r2_next     = r2_reg;
        sq_v_next   = sq_v_reg;
        sq_res_next = sq_res_reg;
        sq_bit_next = sq_bit_reg;
        num_next    = num_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        den_next    = den_reg;
        g_next      = g_reg;
        u_next      = u_reg;
        prod_next   = prod_reg;
        acc_next    = acc_reg;
        skip_next   = skip_reg;
        clip_next   = clip_reg;
        res_next    = res_reg;
        case (state_reg)
            nbga_pkg::S_IDLE:
                if (req_acc)
                begin
                    idx_next  = req.body_index;
                    j_next    = 11'd0;
                    acc_next  = '0;
                    skip_next = 1'b0;
                    clip_next = 1'b0;
                    res_next  = '0;
                    if (req.opcode == nbga_pkg::OP_LOAD)
                        res_next.status = ({1'b0, req.body_index} < nbga_pkg::MAX_BODIES)
                                          ? nbga_pkg::ST_OK : nbga_pkg::ST_RANGE;
                    else if ({1'b0, req.body_index} >= n_use)
                        res_next.status = nbga_pkg::ST_RANGE;
                end
            nbga_pkg::S_TCAP:
            begin
                tgt_next[0] = rd_data_reg[95:64];
                tgt_next[1] = rd_data_reg[63:32];
                tgt_next[2] = rd_data_reg[31:0];
            end
            nbga_pkg::S_JCAP:
            begin
                mass_next = rd_data_reg[127:96];
                d_next[0] = {rd_data_reg[95], rd_data_reg[95:64]} - {tgt_reg[0][31], tgt_reg[0]};
                d_next[1] = {rd_data_reg[63], rd_data_reg[63:32]} - {tgt_reg[1][31], tgt_reg[1]};
                d_next[2] = {rd_data_reg[31], rd_data_reg[31:0]} - {tgt_reg[2][31], tgt_reg[2]};
                r2_next   = 64'd0;
                ax_next   = 2'd0;
            end
            nbga_pkg::S_SQ:
            begin
                r2_next = r2_reg + mul_p[65:2];
                ax_next = (ax_reg == 2'd2) ? 2'd0 : ax_reg + 2'd1;
            end
            nbga_pkg::S_RCHK:
                if (r2_reg == 64'd0)
                    skip_next = 1'b1;
                else
                begin
                    sq_v_next   = r2_reg;
                    sq_res_next = 64'd0;
                    sq_bit_next = 64'h4000_0000_0000_0000;
                    cnt_next    = 7'd0;
                end
            nbga_pkg::S_SQRT:
            begin
                if (sq_ge)
                begin
                    sq_v_next   = sq_v_reg - sq_sum;
                    sq_res_next = (sq_res_reg >> 1) + sq_bit_reg;
                end
                else
                    sq_res_next = sq_res_reg >> 1;
                sq_bit_next = sq_bit_reg >> 2;
                cnt_next    = cnt_reg + 7'd1;
                // Start the mass division over r2 on the last step.
                if (cnt_reg == nbga_pkg::SQRT_LAST)
                begin
                    num_next = {mass_reg, 38'b0};
                    den_next = r2_reg;
                    rem_next = 65'd0;
                    quo_next = 70'd0;
                    cnt_next = 7'd0;
                end
            end
            nbga_pkg::S_GDIV:
            begin
                num_next = {num_reg[68:0], 1'b0};
                rem_next = rem_step;
                quo_next = quo_step;
                cnt_next = cnt_reg + 7'd1;
                // Cap the mass term and start the x-axis direction division.
                if (cnt_reg == nbga_pkg::DIV_LAST)
                begin
                    g_next   = (quo_step[69:62] != 8'd0) ? {1'b1, 62'b0} : {1'b0, quo_step[61:0]};
                    num_next = {8'b0, mag_cur[32:0], 29'b0};
                    den_next = {32'b0, sq_res_reg[31:0]};
                    rem_next = 65'd0;
                    quo_next = 70'd0;
                    cnt_next = 7'd0;
                end
            end
            nbga_pkg::S_UDIV:
            begin
                num_next = {num_reg[68:0], 1'b0};
                rem_next = rem_step;
                quo_next = quo_step;
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == nbga_pkg::DIV_LAST)
                begin
                    u_next    = quo_step[61:0];
                    prod_next = 128'd0;
                    cnt_next  = 7'd0;
                end
            end
            nbga_pkg::S_MUL:
            begin
                prod_next = prod_reg + pp_shift;
                cnt_next  = cnt_reg + 7'd1;
            end
            nbga_pkg::S_ACC:
            begin
                acc_next[ax_reg] = acc_sum;
                clip_next        = clip_reg | term_clip;
                if (ax_reg != 2'd2)
                begin
                    ax_next  = ax_reg + 2'd1;
                    num_next = {8'b0, mag_nxt[32:0], 29'b0};
                    den_next = {32'b0, sq_res_reg[31:0]};
                    rem_next = 65'd0;
                    quo_next = 70'd0;
                    cnt_next = 7'd0;
                end
                else
                    ax_next = 2'd0;
            end
            nbga_pkg::S_NEXT:
                j_next = j_reg + 11'd1;
            nbga_pkg::S_SAT:
            begin
                res_next.acc_x = sat_val[0];
                res_next.acc_y = sat_val[1];
                res_next.acc_z = sat_val[2];
                if (clip_reg || sat_hit != 3'b000)
                    res_next.status = nbga_pkg::ST_SAT;
                else if (skip_reg)
                    res_next.status = nbga_pkg::ST_SKIP;
                else
                    res_next.status = nbga_pkg::ST_OK;
            end
            default:
            begin
            end
        endcase
    end

    // Body store write and registered read.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            body_mem[req.body_index] <= {req.body_mass, req.pos_x, req.pos_y, req.pos_z};
        if (rd_en)
            rd_data_reg <= body_mem[rd_addr];
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= nbga_pkg::S_IDLE;
            body_count_reg <= 11'd0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                body_count_reg <= cfg_wdata;
            if (state_reg == nbga_pkg::S_DONE && rsp_free)
                rsp_valid_reg <= 1'b1;
            else if (!rsp_stall)
                rsp_valid_reg <= 1'b0;
        end
    end

    // Datapath registers and the result word.
    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        j_reg      <= j_next;
        ax_reg     <= ax_next;
        cnt_reg    <= cnt_next;
        tgt_reg    <= tgt_next;
        mass_reg   <= mass_next;
        d_reg      <= d_next;
        r2_reg     <= r2_next;
        sq_v_reg   <= sq_v_next;
        sq_res_reg <= sq_res_next;
        sq_bit_reg <= sq_bit_next;
        num_reg    <= num_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        den_reg    <= den_next;
        g_reg      <= g_next;
        u_reg      <= u_next;
        prod_reg   <= prod_next;
        acc_reg    <= acc_next;
        skip_reg   <= skip_next;
        clip_reg   <= clip_next;
        res_reg    <= res_next;
        if (state_reg == nbga_pkg::S_DONE && rsp_free)
            rsp_reg <= res_reg;
    end

    // The target body never interacts with itself.
    a_no_self: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == nbga_pkg::S_JCAP |-> j_reg != {1'b0, idx_reg})
        else $error("target body visited as a source");

    // The body loop stays below the active count.
    a_loop_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == nbga_pkg::S_JRD |-> j_reg < n_use)
        else $error("body loop ran past the active count");

    // Direction divisions use a divisor that fits the square-root width.
    a_udiv_den: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == nbga_pkg::S_UDIV |-> den_reg[63:32] == 32'd0 && den_reg != 64'd0)
        else $error("direction divisor out of range");

    // An index error carries a zero acceleration.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_reg.status == nbga_pkg::ST_RANGE |->
            rsp_reg.acc_x == 48'd0 && rsp_reg.acc_y == 48'd0 && rsp_reg.acc_z == 48'd0)
        else $error("index error with nonzero acceleration");

endmodule

// File: sim/nbody_gravity_acceleration_top_tb.sv
// Self-checking testbench for the direct-sum gravity kernel.
`timescale 1ns / 1ps

// Holds a copy of the body store and body_count, and the queue of expected result words.
class gravity_scoreboard;
    logic [31:0] mass_mem [1024];
    logic [31:0] px [1024];
    logic [31:0] py [1024];
    logic [31:0] pz [1024];
    logic [10:0] body_count;
    nbga_pkg::rsp_t accel_q [$];
    int errors;

    function new();
        body_count = '0;
        errors = 0;
    endfunction

    function void set_count(logic [10:0] v);
        body_count = v;
    endfunction

    function int pending();
        return accel_q.size();
    endfunction

    // Integer square root, floor.
    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Works out the result word of one accepted input word and updates the store.
    function automatic nbga_pkg::rsp_t gravity_result(nbga_pkg::req_t w);
        nbga_pkg::rsp_t r;
        int n;
        int idx;
        longint acc [3];
        longint d [3];
        longint unsigned mg [3];
        longint unsigned r2;
        longint unsigned rt;
        longint unsigned g;
        longint unsigned u;
        logic [127:0] wide;
        bit clip;
        bit skipped;
        r = '0;
        idx = w.body_index;
        n = (body_count > 11'd1024) ? 1024 : body_count;
        clip = 0;
        skipped = 0;
        acc[0] = 0;
        acc[1] = 0;
        acc[2] = 0;
        if (w.opcode == nbga_pkg::OP_LOAD)
        begin
            // Index is 10 bits, so every load lands in the store.
            mass_mem[idx] = w.body_mass;
            px[idx] = w.pos_x;
            py[idx] = w.pos_y;
            pz[idx] = w.pos_z;
            r.status = nbga_pkg::ST_OK;
            return r;
        end
        if (idx >= n)
        begin
            r.status = nbga_pkg::ST_RANGE;
            return r;
        end
        for (int j = 0; j < n; j++)
        begin
            if (j == idx)
                continue;
            d[0] = longint'($signed(px[j])) - longint'($signed(px[idx]));
            d[1] = longint'($signed(py[j])) - longint'($signed(py[idx]));
            d[2] = longint'($signed(pz[j])) - longint'($signed(pz[idx]));
            r2 = 0;
            for (int a = 0; a < 3; a++)
            begin
                mg[a] = (d[a] < 0) ? unsigned'(-d[a]) : unsigned'(d[a]);
                r2 = r2 + ((mg[a] * mg[a]) >> 2);
            end
            rt = int_sqrt(r2);
            // Bodies closer than the distance resolution are skipped.
            if (rt == 0)
            begin
                skipped = 1;
                continue;
            end
            wide = ({96'd0, mass_mem[j]} << 38) / {64'd0, r2};
            g = (wide >= (128'd1 << 62)) ? (64'd1 << 62) : wide[63:0];
            for (int a = 0; a < 3; a++)
            begin
                u = (mg[a] << 29) / rt;
                wide = ({64'd0, u} * {64'd0, g}) >> 30;
                if (wide >= (128'd1 << 50))
                begin
                    wide = 128'd1 << 50;
                    clip = 1;
                end
                if (d[a] < 0)
                    acc[a] = acc[a] - longint'(wide[63:0]);
                else
                    acc[a] = acc[a] + longint'(wide[63:0]);
            end
        end
        // Clamp to the 48-bit signed range.
        for (int a = 0; a < 3; a++)
        begin
            if (acc[a] > 64'sd140737488355327)
            begin
                acc[a] = 64'sd140737488355327;
                clip = 1;
            end
            else if (acc[a] < -64'sd140737488355328)
            begin
                acc[a] = -64'sd140737488355328;
                clip = 1;
            end
        end
        r.acc_x = acc[0][47:0];
        r.acc_y = acc[1][47:0];
        r.acc_z = acc[2][47:0];
        r.status = clip ? nbga_pkg::ST_SAT : (skipped ? nbga_pkg::ST_SKIP : nbga_pkg::ST_OK);
        return r;
    endfunction

    function void note_word(nbga_pkg::req_t w);
        accel_q = {accel_q, gravity_result(w)};
    endfunction

    function void check_word(nbga_pkg::rsp_t got);
        nbga_pkg::rsp_t exp_w;
        if (accel_q.size() == 0)
        begin
            $error("unexpected result word acc_x=%h status=%0d", got.acc_x, got.status);
            errors++;
            return;
        end
        exp_w = accel_q.pop_front();
        if (got.acc_x !== exp_w.acc_x)
        begin
            $error("acc_x expected %h actual %h", exp_w.acc_x, got.acc_x);
            errors++;
        end
        if (got.acc_y !== exp_w.acc_y)
        begin
            $error("acc_y expected %h actual %h", exp_w.acc_y, got.acc_y);
            errors++;
        end
        if (got.acc_z !== exp_w.acc_z)
        begin
            $error("acc_z expected %h actual %h", exp_w.acc_z, got.acc_z);
            errors++;
        end
        if (got.status !== exp_w.status)
        begin
            $error("status expected %0d actual %0d", exp_w.status, got.status);
            errors++;
        end
    endfunction
endclass

module nbody_gravity_acceleration_top_tb;

    localparam int CYCLE_LIMIT = 12000000;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    nbga_pkg::req_t req;
    logic rsp_valid;
    logic rsp_stall;
    nbga_pkg::rsp_t rsp;
    logic cfg_we;
    logic [10:0] cfg_wdata;

    gravity_scoreboard sb;
    int cycles;
    int sent;

    nbody_gravity_acceleration_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Clock generation.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[nbody_gravity_acceleration_top] ERROR");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55)
            return 0;
        else if (p < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Result monitor: a word is taken when valid is high and stall is low.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            sb.check_word(rsp);
    end

    // Receiver stall pattern.
    initial
    begin
        int n;
        rsp_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            n = gap_len();
            if (n > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge clk);
        end
    end

    // Sends one input word and notes it when accepted.
    task automatic send_word(nbga_pkg::req_t w);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            req_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= w;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        sb.note_word(w);
        sent++;
    endtask

    task automatic load_body(int idx, logic [31:0] m, logic [31:0] x, logic [31:0] y,
                             logic [31:0] z);
        nbga_pkg::req_t w;
        w.opcode = nbga_pkg::OP_LOAD;
        w.body_index = idx[9:0];
        w.body_mass = m;
        w.pos_x = x;
        w.pos_y = y;
        w.pos_z = z;
        send_word(w);
    endtask

    task automatic query_body(int idx);
        nbga_pkg::req_t w;
        w = '0;
        w.opcode = nbga_pkg::OP_QUERY;
        w.body_index = idx[9:0];
        w.body_mass = $urandom();
        w.pos_x = $urandom();
        send_word(w);
    endtask

    // Waits for the block to drain, then writes body_count.
    task automatic write_count(logic [10:0] v);
        req_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_count(v);
    endtask

    // Random position: full range, or a tight cluster to reach close encounters.
    function automatic logic [31:0] rand_coord(bit near, logic [31:0] base);
        if (near)
            return base + $urandom_range(0, 6) - 3;
        return $urandom();
    endfunction

    function automatic logic [31:0] rand_mass();
        int p;
        p = $urandom_range(0, 9);
        if (p == 0)
            return 32'hffff_ffff;
        if (p == 1)
            return 32'd0;
        return $urandom();
    endfunction

    task automatic load_random(int idx, bit near, logic [31:0] base);
        load_body(idx, rand_mass(), rand_coord(near, base), rand_coord(near, base + 32'h100),
                  rand_coord(near, base - 32'h100));
    endtask

    initial
    begin
        int n;
        int p;
        bit near;
        logic [31:0] base;
        sb = new();
        cycles = 0;
        sent = 0;
        rst_n = 1'b0;
        req_valid <= 1'b0;
        req <= '0;
        cfg_we <= 1'b0;
        cfg_wdata <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // With no bodies in use every query is out of range.
        write_count(11'd0);
        query_body(0);
        query_body(1023);

        // Directed: coincident body, saturation and extreme fields.
        load_body(0, 32'hffff_ffff, 32'h0, 32'h0, 32'h0);
        load_body(1, 32'hffff_ffff, 32'h2, 32'h0, 32'h0);
        load_body(2, 32'h0001_0000, 32'h0, 32'h0, 32'h0);
        load_body(3, 32'h0, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
        load_body(4, 32'h0001_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
        load_body(1023, 32'h0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        write_count(11'd5);
        query_body(0);
        query_body(2);
        query_body(3);
        query_body(4);
        query_body(5);
        query_body(1023);
        write_count(11'd3);
        query_body(2);
        write_count(11'd2);
        query_body(1);
        load_body(1, 32'h0001_0000, 32'h0, 32'h0001_0000, 32'h0);
        query_body(0);
        write_count(11'd1);
        query_body(0);
        query_body(1);

        // Random phases with small body counts.
        while (sent < 560)
        begin
            p = $urandom_range(0, 19);
            n = (p == 0) ? 0 : ((p == 1) ? $urandom_range(9, 16) : $urandom_range(1, 6));
            write_count(n[10:0]);
            near = ($urandom_range(0, 2) == 0);
            base = $urandom();
            for (int j = 0; j < n; j++)
                load_random(j, near && ($urandom_range(0, 3) != 0), base);
            repeat ($urandom_range(6, 14))
            begin
                p = $urandom_range(0, 99);
                if (p < 60 && n > 0)
                    query_body($urandom_range(0, n - 1));
                else if (p < 75)
                    query_body($urandom_range(0, 1023));
                else
                    load_random($urandom_range(0, 1023), near, base);
            end
        end

        // Drain and report.
        req_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("[nbody_gravity_acceleration_top] OK");
        else
            $display("[nbody_gravity_acceleration_top] ERROR");
        $finish;
    end
endmodule

// File: nbody_gravity_acceleration_top.f
src/nbga_pkg.sv
src/nbody_gravity_acceleration_top.sv
sim/nbody_gravity_acceleration_top_tb.sv
